[src/faa_pkg.sv]
// ----------------------------------------------------------------------------
// faa_pkg
// Shared types and constants for the fault alarm annunciator: opcodes,
// test command codes, register indexes, widths and register reset values.
// ----------------------------------------------------------------------------
package faa_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CNT_W         = 32;
    localparam int TICKS_W       = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_FAULT_LATCH = 3'd1,
        OP_FAULT_CLEAR = 3'd2,
        OP_LED_TEST    = 3'd3,
        OP_BUZZ_TEST   = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUZZER_ENABLED     = 2'd0,
        CFG_BUZZER_PULSE_TICKS = 2'd1,
        CFG_LED_TEST_TICKS     = 2'd2
    } cfg_index_t;

    localparam logic [1:0] CMD_CANCEL = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;

    localparam logic               BUZZER_ENABLED_RST     = 1'b1;
    localparam logic [TICKS_W-1:0] BUZZER_PULSE_TICKS_RST = 16'd500;
    localparam logic [TICKS_W-1:0] LED_TEST_TICKS_RST     = 16'd1000;

endpackage

[src/fault_alarm_annunciator.sv]
// ----------------------------------------------------------------------------
// fault_alarm_annunciator
// Fault LED and buzzer annunciator with manual LED and buzzer tests, driven
// by a stream of tick and event items; one status result per item.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | opcode, fault_reason, test_command, test_safe
//  out     | out_valid/out_stall| led_on .. buzzer_test_running (11 fields)
//  cfg     | cfg_write          | cfg_index, cfg_data
//
//  One item per clock while out is not stalled; the input register takes
//  the item, then the state update lands in the result register.
//  The rate is set by the single state update between the two registers.
//  Reset puts all state and the valid bits of both registers at their reset values at once; register data is not reset.
//  A stall on out holds the result and backs up into the input register;
//  in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
module fault_alarm_annunciator #(
    parameter int TIME_BITS = faa_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      opcode,
    input  logic [1:0]                      fault_reason,
    input  logic [1:0]                      test_command,
    input  logic                            test_safe,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            led_on,
    output logic                            buzzer_on,
    output logic [1:0]                      alarm_reason,
    output logic                            fault_issued,
    output logic [faa_pkg::CNT_W-1:0]       pulse_total,
    output logic [faa_pkg::CNT_W-1:0]       clear_total,
    output logic [faa_pkg::CNT_W-1:0]       last_pulse_length,
    output logic [faa_pkg::CNT_W-1:0]       led_test_total,
    output logic [faa_pkg::CNT_W-1:0]       buzzer_test_total,
    output logic                            led_test_running,
    output logic                            buzzer_test_running,

    input  logic                            cfg_write,
    input  logic [faa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [faa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = faa_pkg::CNT_W;
    localparam int TW = faa_pkg::TICKS_W;

    // configuration
    logic          buzzer_enabled_reg;
    logic [TW-1:0] buzzer_pulse_ticks_reg;
    logic [TW-1:0] led_test_ticks_reg;

    // input register
    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] s1_opcode_reg;
    logic [1:0] s1_reason_reg;
    logic [1:0] s1_cmd_reg;
    logic       s1_safe_reg;
    logic       s1_adv;
    logic       s1_fire;
    logic       in_fire;

    // annunciator state
    logic [TIME_BITS-1:0] time_now_reg, time_now_next;
    logic                 led_level_reg, led_level_next;
    logic                 led_wanted_reg, led_wanted_next;
    logic                 led_apply_reg, led_apply_next;
    logic                 buzzer_level_reg, buzzer_level_next;
    logic                 buzzer_start_reg, buzzer_start_next;
    logic                 buzzer_stop_reg, buzzer_stop_next;
    logic [1:0]           reason_reg, reason_next;
    logic                 issued_reg, issued_next;
    logic                 pulse_running_reg, pulse_running_next;
    logic [TIME_BITS-1:0] pulse_start_reg, pulse_start_next;
    logic [CW-1:0]        last_length_reg, last_length_next;
    logic [CW-1:0]        pulse_cnt_reg, pulse_cnt_next;
    logic [CW-1:0]        clear_cnt_reg, clear_cnt_next;
    logic [1:0]           led_cmd_reg, led_cmd_next;
    logic                 led_test_reg, led_test_next;
    logic [TIME_BITS-1:0] led_test_start_reg, led_test_start_next;
    logic [CW-1:0]        led_test_mark_reg, led_test_mark_next;
    logic [CW-1:0]        led_test_cnt_reg, led_test_cnt_next;
    logic [1:0]           buzz_cmd_reg, buzz_cmd_next;
    logic                 buzz_test_reg, buzz_test_next;
    logic [TIME_BITS-1:0] buzz_test_start_reg, buzz_test_start_next;
    logic [CW-1:0]        buzz_test_cnt_reg, buzz_test_cnt_next;

    // result register
    logic out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign s1_adv   = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_enabled_reg     <= faa_pkg::BUZZER_ENABLED_RST;
            buzzer_pulse_ticks_reg <= faa_pkg::BUZZER_PULSE_TICKS_RST;
            led_test_ticks_reg     <= faa_pkg::LED_TEST_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (faa_pkg::cfg_index_t'(cfg_index))
                faa_pkg::CFG_BUZZER_ENABLED:     buzzer_enabled_reg     <= cfg_data[0];
                faa_pkg::CFG_BUZZER_PULSE_TICKS: buzzer_pulse_ticks_reg <= cfg_data[TW-1:0];
                faa_pkg::CFG_LED_TEST_TICKS:     led_test_ticks_reg     <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state update for the item in the input register; services run in
    // the fixed order of a tick, each seeing what the previous one left
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [TIME_BITS-1:0] el;
        logic [TIME_BITS-1:0] pulse_ticks;
        logic [TIME_BITS-1:0] led_ticks;

        pulse_ticks = TIME_BITS'(buzzer_pulse_ticks_reg);
        led_ticks   = TIME_BITS'(led_test_ticks_reg);
        el          = '0;

        time_now_next        = time_now_reg;
        led_level_next       = led_level_reg;
        led_wanted_next      = led_wanted_reg;
        led_apply_next       = led_apply_reg;
        buzzer_level_next    = buzzer_level_reg;
        buzzer_start_next    = buzzer_start_reg;
        buzzer_stop_next     = buzzer_stop_reg;
        reason_next          = reason_reg;
        issued_next          = issued_reg;
        pulse_running_next   = pulse_running_reg;
        pulse_start_next     = pulse_start_reg;
        last_length_next     = last_length_reg;
        pulse_cnt_next       = pulse_cnt_reg;
        clear_cnt_next       = clear_cnt_reg;
        led_cmd_next         = led_cmd_reg;
        led_test_next        = led_test_reg;
        led_test_start_next  = led_test_start_reg;
        led_test_mark_next   = led_test_mark_reg;
        led_test_cnt_next    = led_test_cnt_reg;
        buzz_cmd_next        = buzz_cmd_reg;
        buzz_test_next       = buzz_test_reg;
        buzz_test_start_next = buzz_test_start_reg;
        buzz_test_cnt_next   = buzz_test_cnt_reg;

        unique case (faa_pkg::opcode_t'(s1_opcode_reg))
            faa_pkg::OP_TICK:
            begin
                time_now_next = time_now_reg + TIME_BITS'(1);

                // buzzer test loses its grant: stop at this tick
                if (buzz_test_next && (issued_next || !s1_safe_reg))
                begin
                    buzzer_stop_next = 1'b1;
                    buzz_cmd_next    = faa_pkg::CMD_CANCEL;
                end

                if (led_apply_next)
                begin
                    led_level_next = led_wanted_next;
                    led_apply_next = 1'b0;
                end

                // LED test
                if (led_test_next)
                begin
                    el = time_now_next - led_test_start_next;
                    if (led_cmd_next != faa_pkg::CMD_START ||
                        pulse_cnt_next != led_test_mark_next ||
                        issued_next || !s1_safe_reg || el >= led_ticks)
                    begin
                        led_test_next       = 1'b0;
                        led_test_start_next = '0;
                        led_cmd_next        = faa_pkg::CMD_CANCEL;
                        if (!issued_next)
                        begin
                            led_level_next = 1'b0;
                        end
                    end
                end
                else if (led_cmd_next != faa_pkg::CMD_CANCEL)
                begin
                    if (led_cmd_next != faa_pkg::CMD_START || issued_next || !s1_safe_reg)
                    begin
                        led_cmd_next = faa_pkg::CMD_CANCEL;
                    end
                    else
                    begin
                        led_level_next      = 1'b1;
                        led_test_next       = 1'b1;
                        led_test_start_next = time_now_next;
                        led_test_mark_next  = pulse_cnt_next;
                        led_test_cnt_next   = led_test_cnt_next + CW'(1);
                    end
                end

                // buzzer stop
                if (buzzer_stop_next)
                begin
                    buzzer_stop_next  = 1'b0;
                    buzzer_level_next = 1'b0;
                    if (pulse_running_next)
                    begin
                        el               = time_now_next - pulse_start_next;
                        last_length_next = CW'(el);
                    end
                    pulse_running_next = 1'b0;
                    if (buzz_test_next)
                    begin
                        buzz_test_next = 1'b0;
                        buzz_cmd_next  = faa_pkg::CMD_CANCEL;
                    end
                end

                // buzzer start on a new fault
                if (buzzer_start_next)
                begin
                    buzzer_start_next = 1'b0;
                    if (issued_next && buzzer_enabled_reg)
                    begin
                        buzzer_level_next  = 1'b1;
                        pulse_start_next   = time_now_next;
                        last_length_next   = '0;
                        pulse_running_next = 1'b1;
                    end
                end

                // fault pulse timeout
                if (pulse_running_next)
                begin
                    el = time_now_next - pulse_start_next;
                    if (el >= pulse_ticks)
                    begin
                        buzzer_level_next  = 1'b0;
                        last_length_next   = CW'(el);
                        pulse_running_next = 1'b0;
                    end
                end

                // buzzer test
                if (buzz_test_next)
                begin
                    el = time_now_next - buzz_test_start_next;
                    if (!s1_safe_reg || issued_next || el >= pulse_ticks)
                    begin
                        buzzer_level_next = 1'b0;
                        buzz_test_next    = 1'b0;
                        buzz_cmd_next     = faa_pkg::CMD_CANCEL;
                    end
                end
                else if (buzz_cmd_next != faa_pkg::CMD_CANCEL)
                begin
                    if (buzz_cmd_next != faa_pkg::CMD_START || !s1_safe_reg ||
                        issued_next || buzzer_level_next ||
                        buzzer_start_next || buzzer_stop_next)
                    begin
                        buzz_cmd_next = faa_pkg::CMD_CANCEL;
                    end
                    else
                    begin
                        buzzer_level_next    = 1'b1;
                        buzz_test_next       = 1'b1;
                        buzz_test_start_next = time_now_next;
                        buzz_test_cnt_next   = buzz_test_cnt_next + CW'(1);
                    end
                end
            end

            faa_pkg::OP_FAULT_LATCH:
            begin
                if (s1_reason_reg != 2'd0)
                begin
                    if (issued_reg)
                    begin
                        reason_next = reason_reg | s1_reason_reg;
                    end
                    else
                    begin
                        reason_next       = s1_reason_reg;
                        issued_next       = 1'b1;
                        led_wanted_next   = 1'b1;
                        led_apply_next    = 1'b1;
                        buzzer_start_next = 1'b1;
                        last_length_next  = '0;
                        pulse_cnt_next    = pulse_cnt_reg + CW'(1);
                    end
                end
            end

            faa_pkg::OP_FAULT_CLEAR:
            begin
                led_wanted_next   = 1'b0;
                led_apply_next    = 1'b1;
                buzzer_start_next = 1'b0;
                buzzer_stop_next  = 1'b1;
                reason_next       = 2'd0;
                issued_next       = 1'b0;
                clear_cnt_next    = clear_cnt_reg + CW'(1);
            end

            faa_pkg::OP_LED_TEST:  led_cmd_next  = s1_cmd_reg;
            faa_pkg::OP_BUZZ_TEST: buzz_cmd_next = s1_cmd_reg;

            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg <= opcode;
            s1_reason_reg <= fault_reason;
            s1_cmd_reg    <= test_command;
            s1_safe_reg   <= test_safe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_now_reg        <= '0;
            led_level_reg       <= 1'b0;
            led_wanted_reg      <= 1'b0;
            led_apply_reg       <= 1'b1;
            buzzer_level_reg    <= 1'b0;
            buzzer_start_reg    <= 1'b0;
            buzzer_stop_reg     <= 1'b1;
            reason_reg          <= 2'd0;
            issued_reg          <= 1'b0;
            pulse_running_reg   <= 1'b0;
            pulse_start_reg     <= '0;
            last_length_reg     <= '0;
            pulse_cnt_reg       <= '0;
            clear_cnt_reg       <= '0;
            led_cmd_reg         <= faa_pkg::CMD_CANCEL;
            led_test_reg        <= 1'b0;
            led_test_start_reg  <= '0;
            led_test_mark_reg   <= '0;
            led_test_cnt_reg    <= '0;
            buzz_cmd_reg        <= faa_pkg::CMD_CANCEL;
            buzz_test_reg       <= 1'b0;
            buzz_test_start_reg <= '0;
            buzz_test_cnt_reg   <= '0;
        end
        else if (s1_fire)
        begin
            time_now_reg        <= time_now_next;
            led_level_reg       <= led_level_next;
            led_wanted_reg      <= led_wanted_next;
            led_apply_reg       <= led_apply_next;
            buzzer_level_reg    <= buzzer_level_next;
            buzzer_start_reg    <= buzzer_start_next;
            buzzer_stop_reg     <= buzzer_stop_next;
            reason_reg          <= reason_next;
            issued_reg          <= issued_next;
            pulse_running_reg   <= pulse_running_next;
            pulse_start_reg     <= pulse_start_next;
            last_length_reg     <= last_length_next;
            pulse_cnt_reg       <= pulse_cnt_next;
            clear_cnt_reg       <= clear_cnt_next;
            led_cmd_reg         <= led_cmd_next;
            led_test_reg        <= led_test_next;
            led_test_start_reg  <= led_test_start_next;
            led_test_mark_reg   <= led_test_mark_next;
            led_test_cnt_reg    <= led_test_cnt_next;
            buzz_cmd_reg        <= buzz_cmd_next;
            buzz_test_reg       <= buzz_test_next;
            buzz_test_start_reg <= buzz_test_start_next;
            buzz_test_cnt_reg   <= buzz_test_cnt_next;
        end
    end

    // result register: status after the item
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            led_on              <= led_level_next;
            buzzer_on           <= buzzer_level_next;
            alarm_reason        <= reason_next;
            fault_issued        <= issued_next;
            pulse_total         <= pulse_cnt_next;
            clear_total         <= clear_cnt_next;
            last_pulse_length   <= last_length_next;
            led_test_total      <= led_test_cnt_next;
            buzzer_test_total   <= buzz_test_cnt_next;
            led_test_running    <= led_test_next;
            buzzer_test_running <= buzz_test_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_issued_has_reason: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg == (reason_reg != 2'd0))
        else $error("latched fault and reason bits disagree");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(time_now_reg) && $stable(pulse_cnt_reg) &&
                     $stable(clear_cnt_reg))
        else $error("state changed with no item processed");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed item gave no result");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free register");

endmodule
